// File: rtl/sdu_pkg.sv
// Shared types and constants for the system-exclusive dump unpacker.
// Used by sdu_step and sysex_dump_unpacker_core; no dependencies.
package sdu_pkg;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_BAD_TYPE   = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0] byte_position;
    logic       is_program_dump;
    logic [2:0] group_position;
    logic [7:0] guide_byte;
    status_t    reject_code;
  } state_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] decoded_value;
    logic       has_data;
    logic       end_of_message;
    status_t    status;
  } result_t;

  localparam logic [7:0] SYSEX_START     = 8'hF0;
  localparam logic [7:0] SYSEX_END       = 8'hF7;
  localparam logic [7:0] MFR_ID_0        = 8'h00;
  localparam logic [7:0] MFR_ID_1        = 8'h20;
  localparam logic [7:0] MFR_ID_2        = 8'h32;
  localparam logic [7:0] MODEL_ID        = 8'h20;
  localparam logic [7:0] MSG_PROGRAM     = 8'h02;
  localparam logic [7:0] MSG_EDIT_BUFFER = 8'h04;

  localparam logic [3:0] POS_MFR_0       = 4'd1;
  localparam logic [3:0] POS_MFR_1       = 4'd2;
  localparam logic [3:0] POS_MFR_2       = 4'd3;
  localparam logic [3:0] POS_MODEL       = 4'd4;
  localparam logic [3:0] POS_MSG_TYPE    = 4'd6;
  localparam logic [3:0] POS_MIN_FINAL   = 4'd9;
  localparam logic [3:0] POS_SAT         = 4'd10;
  localparam logic [3:0] START_PROGRAM   = 4'd10;
  localparam logic [3:0] START_EDIT      = 4'd8;
  localparam logic [2:0] GROUP_LAST      = 3'd7;

endpackage

// File: rtl/sdu_step.sv
// Combinational per-beat logic: header checks, group unpacking and the end marker.
// Depends on sdu_pkg.
module sdu_step (
  input  sdu_pkg::state_t  cur,
  input  logic [7:0]       data_byte,
  input  logic             final_byte,
  output sdu_pkg::state_t  nxt,
  output sdu_pkg::result_t res
);
  import sdu_pkg::*;

  logic [3:0] pos;
  logic       hdr_bad;
  logic       payload;
  logic       start_ok;
  logic [2:0] idx;
  logic       has;
  logic [7:0] val;
  status_t    rej;
  logic       prog;
  status_t    st;

  assign pos = cur.byte_position;
  assign hdr_bad = (pos == 4'd0 && data_byte != SYSEX_START) ||
                   (pos == POS_MFR_0 && data_byte != MFR_ID_0) ||
                   (pos == POS_MFR_1 && data_byte != MFR_ID_1) ||
                   (pos == POS_MFR_2 && data_byte != MFR_ID_2) ||
                   (pos == POS_MODEL && data_byte != MODEL_ID);
  assign idx = cur.group_position - 3'd1;

  always_comb begin
    rej  = cur.reject_code;
    prog = cur.is_program_dump;
    if (cur.reject_code == STATUS_OK) begin
      if (hdr_bad) begin
        rej = STATUS_BAD_HEADER;
      end else if (pos == POS_MSG_TYPE) begin
        if (data_byte == MSG_PROGRAM) begin
          prog = 1'b1;
        end else if (data_byte == MSG_EDIT_BUFFER) begin
          prog = 1'b0;
        end else begin
          rej = STATUS_BAD_TYPE;
        end
      end
    end

    start_ok = prog ? (pos >= START_PROGRAM) : (pos >= START_EDIT);
    payload  = (rej == STATUS_OK) && start_ok && !(final_byte && data_byte == SYSEX_END);

    nxt                 = cur;
    nxt.reject_code     = rej;
    nxt.is_program_dump = prog;
    nxt.byte_position   = (pos < POS_SAT) ? pos + 4'd1 : pos;
    has = 1'b0;
    val = 8'd0;
    if (payload) begin
      if (cur.group_position == 3'd0) begin
        nxt.guide_byte     = data_byte;
        nxt.group_position = 3'd1;
      end else begin
        val = {cur.guide_byte[idx] | data_byte[7], data_byte[6:0]};
        has = 1'b1;
        nxt.group_position = (cur.group_position == GROUP_LAST) ? 3'd0
                                                                : cur.group_position + 3'd1;
      end
    end

    st = (pos < POS_MIN_FINAL) ? STATUS_BAD_HEADER : rej;
    if (final_byte) begin
      nxt = '0;
      if (st != STATUS_OK) begin
        has = 1'b0;
      end
      res.emit           = 1'b1;
      res.end_of_message = 1'b1;
      res.status         = st;
    end else begin
      res.emit           = has;
      res.end_of_message = 1'b0;
      res.status         = STATUS_OK;
    end
    res.has_data      = has;
    res.decoded_value = has ? val : 8'd0;
  end

endmodule

// File: rtl/sysex_dump_unpacker_core.sv
// An accepted beat goes to the input register, and its result then goes to the result register.
// Throughput: one byte per cycle unless stalled, set by one pass from input to result register.
// Reset clears the input and result valid flags and the message state; no clearing pass.
// Top level of the system-exclusive dump unpacker with valid/stall channels.
// Depends on sdu_pkg and sdu_step.
module sysex_dump_unpacker_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] decoded_value,
  output logic       has_data,
  output logic       end_of_message,
  output logic [1:0] status
);
  import sdu_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_final;
  state_t     cur;
  state_t     cur_next;
  result_t    res;
  result_t    out_q;
  logic       out_ready;
  logic       advance;
  logic       in_accept;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_accept = in_valid && !in_stall;

  sdu_step u_step (
    .cur        (cur),
    .data_byte  (s1_byte),
    .final_byte (s1_final),
    .nxt        (cur_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      cur       <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        cur       <= cur_next;
        out_valid <= res.emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte  <= data_byte;
      s1_final <= final_byte;
    end
    if (advance && res.emit) begin
      out_q <= res;
    end
  end

  assign decoded_value  = out_q.decoded_value;
  assign has_data       = out_q.has_data;
  assign end_of_message = out_q.end_of_message;
  assign status         = out_q.status;

endmodule
